@@ hdl/assert_macros.svh @@
// Assertion macros for the subnet address pool allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define SAPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside of reset.
`define SAPA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hdl/sapa_pkg.sv @@
// Shared constants and types of the subnet address pool allocator.
`timescale 1ns / 1ps

package sapa_pkg;

  // Default largest host part, in bits.
  localparam int unsigned MAX_HOST_BITS = 10;

  // Largest bitmap word, as log2 of its bit count.
  localparam int unsigned WORD_LG_MAX = 5;

  localparam int unsigned IP_ADDR_W    = 32;
  localparam int unsigned PREFIX_W     = 5;
  localparam int unsigned FREE_COUNT_W = 11;
  localparam int unsigned CFG_INDEX_W  = 1;

  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 5'd24;
  localparam int unsigned         PREFIX_MAX   = 30;
  localparam int unsigned         RESERVED_HOSTS = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NETWORK_ADDRESS = 1'b0,
    REG_PREFIX_LENGTH   = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_IN_NET = 2'd1,
    ST_NOT_FOUND  = 2'd2
  } status_e;

endpackage

@@ hdl/sapa_bitmap_ram.sv @@
// Simple dual-port bitmap memory with one write port and a registered read port.
`timescale 1ns / 1ps

module sapa_bitmap_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned AddrW = 5,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/subnet_address_pool_allocator_core.sv @@
// Top level of the subnet address pool allocator: control, search and bookkeeping.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Address pool allocator for one IPv4 subnet.
// Requests come in on start/req_type_i/address_i and are taken at a rising edge
// with start high and busy low. Each request returns exactly one result beat on
// status_o/granted_address_o/free_count_o, marked by done_o for one cycle; the
// receiver cannot stall, so every beat must be captured when done_o is high.
// Configuration goes through cfg_we_i/cfg_index_i/cfg_wdata_i (0 network
// address, 1 prefix length); the user must write it only while the block is
// idle, which the block itself does not enforce. The used map lives in a
// bitmap RAM of 2^MaxHostBits bits in words of up to 32 bits (32 words at
// the default). An address outside the subnet is answered in the cycle after
// acceptance. A free takes one RAM read: its word is read at acceptance and
// checked in the scan state, which raises the beat. An allocate scans one
// word per cycle from the word of the start host up to the top word of the
// pool, 1 to NumWords words. Busy is low again during the beat cycle, so the
// next request can be taken at the edge that ends the beat. Reset and every
// configuration write start a clearing pass that rewrites all NumWords words
// with hosts 0, all-ones, all-ones minus one reserved; busy is high in the pass.

module subnet_address_pool_allocator_core #(
  parameter int unsigned MaxHostBits = sapa_pkg::MAX_HOST_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port
  input  logic                                 cfg_we_i,
  input  logic [sapa_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [sapa_pkg::IP_ADDR_W-1:0]       cfg_wdata_i,
  // Request channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 req_type_i,
  input  logic [sapa_pkg::IP_ADDR_W-1:0]       address_i,
  // Result channel
  output logic                                 done_o,
  output logic [1:0]                           status_o,
  output logic [sapa_pkg::IP_ADDR_W-1:0]       granted_address_o,
  output logic [sapa_pkg::FREE_COUNT_W-1:0]    free_count_o
);

  // Bitmap geometry: words of up to 32 host bits.
  localparam int unsigned WordLg   = (MaxHostBits < sapa_pkg::WORD_LG_MAX) ?
                                     MaxHostBits : sapa_pkg::WORD_LG_MAX;
  localparam int unsigned WordBits = 1 << WordLg;
  localparam int unsigned NumWords = 1 << (MaxHostBits - WordLg);
  localparam int unsigned AddrW    = (MaxHostBits > WordLg) ? MaxHostBits - WordLg : 1;
  localparam int unsigned CntW     = MaxHostBits + 1;
  localparam int unsigned AW       = sapa_pkg::IP_ADDR_W;

  localparam logic [5:0] PrefixMin = 6'(32 - MaxHostBits);
  localparam logic [5:0] PrefixMax = 6'(sapa_pkg::PREFIX_MAX);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN
  } state_e;

  // Lowest set bit of a word.
  function automatic logic [WordLg-1:0] lowest_one(input logic [WordBits-1:0] v);
    logic [WordLg-1:0] idx;
    idx = '0;
    for (int i = WordBits - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WordLg'(i);
      end
    end
    return idx;
  endfunction

  state_e                            state_q;
  logic [AddrW-1:0]                  clr_q;
  logic [AW-1:0]                     net_q;
  logic [sapa_pkg::PREFIX_W-1:0]     prefix_q;
  logic [CntW-1:0]                   total_q;
  logic                              done_q;
  sapa_pkg::status_e                 status_q;
  logic [AW-1:0]                     granted_q;
  logic [sapa_pkg::FREE_COUNT_W-1:0] free_q;
  sapa_pkg::req_e                    req_q;
  logic [AddrW-1:0]                  w_q;
  logic [WordLg-1:0]                 h_lo_q;
  logic                              first_q;

  // Derived subnet geometry
  logic [5:0]             prefix_eff;
  logic [5:0]             host_bits;
  logic [CntW-1:0]        pool_size;
  logic [CntW-1:0]        hm_wide;
  logic [MaxHostBits-1:0] hm;
  logic [AW-1:0]          pfx_mask;
  logic [AddrW-1:0]       top_word;
  logic [WordLg-1:0]      top_lo;

  // Request decode
  logic                   in_net;
  logic [AW-1:0]          sel_addr;
  logic [MaxHostBits-1:0] h0;
  logic [AddrW-1:0]       w0;

  // Word search
  logic [WordBits-1:0]    rd_word;
  logic [WordBits-1:0]    below;
  logic [WordBits-1:0]    beyond;
  logic [WordBits-1:0]    avail;
  logic                   hit_alloc;
  logic [WordLg-1:0]      hit_lo;
  logic                   bit_set;
  logic                   at_top;
  logic [MaxHostBits-1:0] h_found;
  logic [WordBits-1:0]    res_word;

  // Counts
  logic [CntW-1:0]                   total_inc;
  logic [CntW-1:0]                   total_dec;
  logic [AW-1:0]                     diff_now;
  logic [AW-1:0]                     diff_inc;
  logic [AW-1:0]                     diff_dec;

  // RAM port
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [WordBits-1:0]  ram_wdata;
  logic [AddrW-1:0]     ram_raddr;

  // Saturate the prefix into the supported range and derive the host mask.
  always_comb begin
    prefix_eff = {1'b0, prefix_q};
    if (prefix_eff < PrefixMin) begin
      prefix_eff = PrefixMin;
    end
    if (prefix_eff > PrefixMax) begin
      prefix_eff = PrefixMax;
    end
    host_bits = 6'd32 - prefix_eff;
    pool_size = CntW'(1) << host_bits;
    hm_wide   = pool_size - CntW'(1);
    hm        = hm_wide[MaxHostBits-1:0];
    pfx_mask  = ~AW'(hm);
    top_word  = AddrW'(hm >> WordLg);
    top_lo    = hm[WordLg-1:0];
  end

  // Decode the request at the port; an all-zero prefix counts as inside.
  always_comb begin
    in_net = ((address_i & pfx_mask) == (net_q & pfx_mask)) ||
             ((address_i & pfx_mask) == '0);
    // Address 0 on allocate starts the search at the network's host bits.
    if ((sapa_pkg::req_e'(req_type_i) == sapa_pkg::REQ_ALLOC) && (address_i == '0)) begin
      sel_addr = net_q;
    end else begin
      sel_addr = address_i;
    end
    h0 = sel_addr[MaxHostBits-1:0] & hm;
    w0 = AddrW'(h0 >> WordLg);
  end

  // Search the word read for this step.
  always_comb begin
    // Hide hosts below the start host in the first word and above the pool top.
    below  = first_q ? ((WordBits'(1) << h_lo_q) - WordBits'(1)) : '0;
    at_top = (w_q == top_word);
    beyond = at_top ?
             ~({WordBits{1'b1}} >> (WordLg'(WordBits - 1) - top_lo)) : '0;
    avail     = ~(rd_word | below | beyond);
    hit_alloc = |avail;
    hit_lo    = lowest_one(avail);
    bit_set   = rd_word[h_lo_q];
    h_found   = MaxHostBits'({w_q, hit_lo});
  end

  // Reserved pattern for the word being cleared.
  always_comb begin
    res_word = '0;
    if (clr_q == '0) begin
      res_word[0] = 1'b1;
    end
    if (clr_q == top_word) begin
      res_word = res_word | (WordBits'(1) << top_lo) |
                 (WordBits'(1) << (top_lo - WordLg'(1)));
    end
  end

  // Free count before and after the request.
  always_comb begin
    total_inc = total_q + CntW'(1);
    total_dec = total_q - CntW'(1);
    diff_now  = AW'(pool_size) - AW'(total_q);
    diff_inc  = AW'(pool_size) - AW'(total_inc);
    diff_dec  = AW'(pool_size) - AW'(total_dec);
  end

  // Steer the RAM: sweep writes while clearing, write back on a hit while scanning.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_q;
    ram_wdata = rd_word;
    ram_raddr = '0;
    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = res_word;
      end
      S_IDLE: begin
        ram_raddr = w0;
      end
      S_SCAN: begin
        // Prefetch the next word in case this one is full.
        ram_raddr = w_q + AddrW'(1);
        if (req_q == sapa_pkg::REQ_FREE) begin
          ram_we    = bit_set;
          ram_wdata = rd_word & ~(WordBits'(1) << h_lo_q);
        end else begin
          ram_we    = hit_alloc;
          ram_wdata = rd_word | (WordBits'(1) << hit_lo);
        end
      end
    endcase
  end

  sapa_bitmap_ram #(
    .Depth (NumWords),
    .AddrW (AddrW),
    .DataW (WordBits)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_word)
  );

  // Control, configuration and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      net_q     <= '0;
      prefix_q  <= sapa_pkg::PREFIX_RESET;
      total_q   <= CntW'(sapa_pkg::RESERVED_HOSTS);
      done_q    <= 1'b0;
      status_q  <= sapa_pkg::ST_OK;
      granted_q <= '0;
      free_q    <= '0;
      req_q     <= sapa_pkg::REQ_ALLOC;
      w_q       <= '0;
      h_lo_q    <= '0;
      first_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (sapa_pkg::cfg_reg_e'(cfg_index_i))
          sapa_pkg::REG_NETWORK_ADDRESS: net_q    <= cfg_wdata_i;
          sapa_pkg::REG_PREFIX_LENGTH:   prefix_q <= cfg_wdata_i[sapa_pkg::PREFIX_W-1:0];
        endcase
        // Restart the clearing pass under the new geometry.
        total_q <= CntW'(sapa_pkg::RESERVED_HOSTS);
        clr_q   <= '0;
        state_q <= S_CLEAR;
      end else begin
        unique case (state_q)
          S_CLEAR: begin
            clr_q <= clr_q + AddrW'(1);
            if (clr_q == AddrW'(NumWords - 1)) begin
              state_q <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (start) begin
              if (!in_net) begin
                // Reject at once; the map is untouched.
                done_q    <= 1'b1;
                status_q  <= sapa_pkg::ST_NOT_IN_NET;
                granted_q <= '0;
                free_q    <= diff_now[sapa_pkg::FREE_COUNT_W-1:0];
              end else begin
                req_q   <= sapa_pkg::req_e'(req_type_i);
                w_q     <= w0;
                h_lo_q  <= h0[WordLg-1:0];
                first_q <= 1'b1;
                state_q <= S_SCAN;
              end
            end
          end
          S_SCAN: begin
            if (req_q == sapa_pkg::REQ_FREE) begin
              done_q    <= 1'b1;
              granted_q <= '0;
              state_q   <= S_IDLE;
              if (bit_set) begin
                total_q  <= total_dec;
                status_q <= sapa_pkg::ST_OK;
                free_q   <= diff_dec[sapa_pkg::FREE_COUNT_W-1:0];
              end else begin
                status_q <= sapa_pkg::ST_NOT_FOUND;
                free_q   <= diff_now[sapa_pkg::FREE_COUNT_W-1:0];
              end
            end else if (hit_alloc) begin
              // Grant the first free host found; it carries the configured prefix.
              done_q    <= 1'b1;
              total_q   <= total_inc;
              status_q  <= sapa_pkg::ST_OK;
              granted_q <= (net_q & pfx_mask) | AW'(h_found);
              free_q    <= diff_inc[sapa_pkg::FREE_COUNT_W-1:0];
              state_q   <= S_IDLE;
            end else if (at_top) begin
              // Pool exhausted above the start host.
              done_q    <= 1'b1;
              status_q  <= sapa_pkg::ST_NOT_FOUND;
              granted_q <= '0;
              free_q    <= diff_now[sapa_pkg::FREE_COUNT_W-1:0];
              state_q   <= S_IDLE;
            end else begin
              // Advance to the next word; its read is already in flight.
              w_q     <= w_q + AddrW'(1);
              first_q <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign granted_address_o = granted_q;
  assign free_count_o      = free_q;

  // A beat follows either a scan step or a request rejected at acceptance.
  `SAPA_ASSERT(a_done_has_source, clk_i, rst_ni, done_o |-> ($past(state_q == S_SCAN) || $past(start && !busy)), "result beat without a request")

  // The used count never exceeds the pool.
  `SAPA_ASSERT_NEVER(a_total_bound, clk_i, rst_ni, total_q > pool_size, "used count above pool size")

  // A failed request never carries an address.
  `SAPA_ASSERT(a_fail_no_grant, clk_i, rst_ni, (done_o && (status_q != sapa_pkg::ST_OK)) |-> (granted_address_o == '0), "address granted on failure")

  // The map is not touched by requests while it is being cleared.
  `SAPA_ASSERT(a_clear_blocks, clk_i, rst_ni, (state_q == S_CLEAR) |=> !done_o, "result beat during clearing pass")

endmodule

@@ sim/subnet_pool_checker.sv @@
`timescale 1ns / 1ps
// Checker for the subnet address pool allocator: tracks the used map and compares each result beat.

module subnet_pool_checker
  import sapa_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [IP_ADDR_W-1:0]    cfg_wdata_i,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic                    req_type_i,
  input  logic [IP_ADDR_W-1:0]    address_i,
  input  logic                    done_i,
  input  logic [1:0]              status_i,
  input  logic [IP_ADDR_W-1:0]    granted_address_i,
  input  logic [FREE_COUNT_W-1:0] free_count_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);

  localparam int PoolDepth = 1 << MAX_HOST_BITS;

  typedef struct packed {
    status_e                 status;
    logic [IP_ADDR_W-1:0]    granted;
    logic [FREE_COUNT_W-1:0] free_count;
  } pool_reply_t;

  logic [IP_ADDR_W-1:0] net_addr;
  logic [PREFIX_W-1:0]  prefix_len;
  bit                   used_map [PoolDepth];
  int                   used_total;
  pool_reply_t          reply_q [$];

  // Host part mask, with the prefix clamped to the range the pool supports.
  function automatic logic [IP_ADDR_W-1:0] host_mask();
    int p;
    p = prefix_len;
    if (p < 32 - MAX_HOST_BITS) p = 32 - MAX_HOST_BITS;
    if (p > PREFIX_MAX) p = PREFIX_MAX;
    return (32'd1 << (32 - p)) - 32'd1;
  endfunction

  function automatic void reserve_pool();
    logic [IP_ADDR_W-1:0] m;
    m = host_mask();
    foreach (used_map[i]) used_map[i] = 1'b0;
    used_map[0]     = 1'b1;
    used_map[m]     = 1'b1;
    used_map[m - 1] = 1'b1;
    used_total      = RESERVED_HOSTS;
  endfunction

  // Apply one request to the pool and return the beat it must produce.
  function automatic pool_reply_t serve_request(req_e kind, logic [IP_ADDR_W-1:0] addr);
    logic [IP_ADDR_W-1:0] m;
    int                   h;
    int                   size;
    pool_reply_t          r;
    m        = host_mask();
    size     = int'(m) + 1;
    r.status = ST_OK;
    r.granted = '0;
    if ((addr & ~m) != (net_addr & ~m) && (addr & ~m) != 0) begin
      r.status = ST_NOT_IN_NET;
    end else if (kind == REQ_ALLOC) begin
      // an all-zero address starts the search at the network's own host bits
      h = int'(((addr == 0) ? net_addr : addr) & m);
      while (h < size && used_map[h]) h++;
      if (h < size) begin
        used_map[h] = 1'b1;
        used_total++;
        r.granted = (net_addr & ~m) | IP_ADDR_W'(h);
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end else begin
      h = int'(addr & m);
      if (used_map[h]) begin
        used_map[h] = 1'b0;
        used_total--;
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    r.free_count = FREE_COUNT_W'(size - used_total);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pool_reply_t want;
    if (!rst_ni) begin
      net_addr         = '0;
      prefix_len       = PREFIX_RESET;
      mismatch_count_o = 0;
      reserve_pool();
      reply_q.delete();
    end else begin
      // retire the beat first so a request taken at the same edge queues behind it
      if (done_i) begin
        if (reply_q.size() == 0) begin
          mismatch_count_o++;
          $display("%0t: result beat with nothing outstanding: status %0d address %h free %0d",
                   $time, status_i, granted_address_i, free_count_i);
        end else begin
          want = reply_q.pop_front();
          if (status_i !== want.status) begin
            mismatch_count_o++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, status_i);
          end
          if (granted_address_i !== want.granted) begin
            mismatch_count_o++;
            $display("%0t: granted address mismatch: expected %h, actual %h",
                     $time, want.granted, granted_address_i);
          end
          if (free_count_i !== want.free_count) begin
            mismatch_count_o++;
            $display("%0t: free count mismatch: expected %0d, actual %0d",
                     $time, want.free_count, free_count_i);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_reg_e'(cfg_index_i) == REG_NETWORK_ADDRESS) net_addr = cfg_wdata_i;
        else prefix_len = cfg_wdata_i[PREFIX_W-1:0];
        reserve_pool();
      end
      if (start_i && !busy_i) reply_q.push_back(serve_request(req_e'(req_type_i), address_i));
    end
    pending_o = reply_q.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Testbench top: drives requests and register writes into the allocator and gives the verdict.

module tb;
  import sapa_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 110;
  // Slowest allocate scans every word of the pool: 32 words.
  localparam int DrainCycles   = 40;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_INDEX_W-1:0]  cfg_index_i;
  logic [IP_ADDR_W-1:0]    cfg_wdata_i;
  logic                    start;
  logic                    busy;
  logic                    req_type_i;
  logic [IP_ADDR_W-1:0]    address_i;
  logic                    done_o;
  logic [1:0]              status_o;
  logic [IP_ADDR_W-1:0]    granted_address_o;
  logic [FREE_COUNT_W-1:0] free_count_o;

  int                      mismatches;
  int                      pending;

  // Stimulus-side view of the subnet, used only to shape addresses.
  logic [IP_ADDR_W-1:0]    cur_net = '0;
  logic [IP_ADDR_W-1:0]    cur_mask = 32'h0000_00ff;
  // Addresses handed out since the last register write; frees draw from here.
  logic [IP_ADDR_W-1:0]    grant_q [$];

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  subnet_address_pool_allocator_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start             (start),
    .busy              (busy),
    .req_type_i        (req_type_i),
    .address_i         (address_i),
    .done_o            (done_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .free_count_o      (free_count_o)
  );

  subnet_pool_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .start_i           (start),
    .busy_i            (busy),
    .req_type_i        (req_type_i),
    .address_i         (address_i),
    .done_i            (done_o),
    .status_i          (status_o),
    .granted_address_i (granted_address_o),
    .free_count_i      (free_count_o),
    .mismatch_count_o  (mismatches),
    .pending_o         (pending)
  );

  // Remember granted addresses so that most frees hit a marked host.
  always @(posedge clk_i) begin
    if (done_o && status_o == ST_OK && granted_address_o != '0) begin
      grant_q.push_back(granted_address_o);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Present one request at a falling edge and hold it until a rising edge
  // takes it with busy low. Leave start high; the caller drops it on a gap.
  task automatic send_request(input req_e kind, input logic [IP_ADDR_W-1:0] addr);
    start      = 1'b1;
    req_type_i = kind;
    address_i  = addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Drop start for a number of cycles and toggle the payload as noise.
  task automatic idle(input int cycles);
    start = 1'b0;
    repeat (cycles) begin
      req_type_i = 1'($urandom);
      address_i  = $urandom;
      @(negedge clk_i);
    end
  endtask

  // Hold off until every outstanding beat has come back.
  task automatic drain();
    start = 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  // Write one register while the block is idle. Give a clearing pass from a
  // previous write time to raise busy, then wait it out.
  task automatic write_reg(input cfg_reg_e idx, input logic [IP_ADDR_W-1:0] data);
    int p;
    drain();
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = $urandom;
    grant_q.delete();
    if (idx == REG_NETWORK_ADDRESS) begin
      cur_net = data;
    end else begin
      p = data[PREFIX_W-1:0];
      if (p < 32 - MAX_HOST_BITS) p = 32 - MAX_HOST_BITS;
      if (p > PREFIX_MAX) p = PREFIX_MAX;
      cur_mask = (32'd1 << (32 - p)) - 32'd1;
    end
  endtask

  initial begin
    int                   prefix_sel;
    int                   pick;
    int                   gap;
    int                   idx;
    bit                   no_gaps;
    req_e                 kind;
    logic [IP_ADDR_W-1:0] host;
    logic [IP_ADDR_W-1:0] addr;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_NETWORK_ADDRESS;
    cfg_wdata_i = '0;
    start       = 1'b0;
    req_type_i  = REQ_ALLOC;
    address_i   = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset setting: network 0, prefix 24, hosts 0, 254 and 255 reserved.
    send_request(REQ_ALLOC, 32'h0000_0000);  // any: host 0 taken, grant host 1
    send_request(REQ_ALLOC, 32'hFFFF_FFFF);  // foreign prefix
    idle(1);
    send_request(REQ_ALLOC, 32'h0000_00FE);  // only reserved hosts above: not found
    send_request(REQ_FREE,  32'h0000_00FF);  // free a reserved host
    send_request(REQ_FREE,  32'h0000_0005);  // free of an unmarked host
    idle(3);
    send_request(REQ_ALLOC, 32'h0000_00FE);  // lands on the host just freed
    send_request(REQ_FREE,  32'h0000_0000);  // release host 0
    send_request(REQ_ALLOC, 32'h0000_0000);  // grant host 0 itself

    // Smallest pool: two host bits, only host 1 free. Network host bits are 3.
    write_reg(REG_NETWORK_ADDRESS, 32'hC0A8_0137);
    write_reg(REG_PREFIX_LENGTH, 32'd30);
    send_request(REQ_ALLOC, 32'h0000_0000);  // start at host 3: nothing above
    send_request(REQ_ALLOC, 32'hC0A8_0101);  // prefix differs from the network: rejected
    send_request(REQ_ALLOC, 32'hC0A8_0100);  // prefix differs from the network: rejected
    send_request(REQ_FREE,  32'h0000_0001);  // zero prefix bits count as inside
    send_request(REQ_ALLOC, 32'h0000_0001);  // grant still carries the prefix
    send_request(REQ_FREE,  32'hC0A8_0200);  // foreign prefix
    send_request(REQ_FREE,  32'hC0A8_0134);  // release reserved host 0

    // Prefix below range saturates to the widest pool; top network address.
    write_reg(REG_NETWORK_ADDRESS, 32'hFFFF_FFFF);
    write_reg(REG_PREFIX_LENGTH, 32'd0);
    send_request(REQ_ALLOC, 32'h0000_0000);  // start at the reserved top host
    send_request(REQ_ALLOC, 32'hFFFF_FFFD);
    send_request(REQ_ALLOC, 32'h0000_03FF);  // zero prefix bits, reserved host
    send_request(REQ_FREE,  32'hFFFF_FFFF);
    send_request(REQ_ALLOC, 32'h0000_0000);  // top host now free

    // Prefix above range saturates to 30; upper data bits are dropped.
    write_reg(REG_PREFIX_LENGTH, 32'hFFFF_FFFF);
    send_request(REQ_ALLOC, 32'h0000_0000);
    send_request(REQ_ALLOC, 32'hFFFF_FFFC);
    send_request(REQ_FREE,  32'h1234_5678);

    // Random phases, mostly small pools so that they fill and drain.
    for (int phase = 0; phase < NumPhases; phase++) begin
      case ($urandom_range(0, 9))
        0:       prefix_sel = 22;
        1:       prefix_sel = 30;
        2:       prefix_sel = $urandom_range(0, 21);
        3:       prefix_sel = 31;
        default: prefix_sel = $urandom_range(26, 30);
      endcase
      case ($urandom_range(0, 9))
        0:       addr = '0;
        1:       addr = '1;
        default: addr = $urandom;
      endcase
      // Write one or both registers, in either order.
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        write_reg(REG_NETWORK_ADDRESS, addr);
        write_reg(REG_PREFIX_LENGTH, ($urandom & ~32'h1F) | prefix_sel);
      end else if (pick < 8) begin
        write_reg(REG_PREFIX_LENGTH, ($urandom & ~32'h1F) | prefix_sel);
        write_reg(REG_NETWORK_ADDRESS, addr);
      end else if (pick < 9) begin
        write_reg(REG_NETWORK_ADDRESS, addr);
      end else begin
        write_reg(REG_PREFIX_LENGTH, ($urandom & ~32'h1F) | prefix_sel);
      end
      no_gaps = ($urandom_range(0, 3) == 0);

      for (int i = 0; i < ItemsPerPhase; i++) begin
        host = $urandom & cur_mask;
        // keep large pools busy near the bottom so searches collide
        if (cur_mask > 63 && $urandom_range(0, 1)) host = $urandom_range(0, 63);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          kind = REQ_ALLOC;
          case ($urandom_range(0, 9))
            0, 1:    addr = '0;
            8:       addr = host;
            9:       addr = $urandom;
            default: addr = (cur_net & ~cur_mask) | host;
          endcase
        end else if (pick < 80 && grant_q.size() > 0) begin
          kind = REQ_FREE;
          idx  = $urandom_range(0, grant_q.size() - 1);
          addr = grant_q[idx];
          grant_q.delete(idx);
        end else if (pick < 92) begin
          kind = REQ_FREE;
          addr = (cur_net & ~cur_mask) | host;
        end else begin
          kind = req_e'($urandom_range(0, 1));
          addr = $urandom;
        end
        send_request(kind, addr);

        if (!no_gaps) begin
          pick = $urandom_range(0, 99);
          if (pick < 65) gap = 0;
          else if (pick < 95) gap = $urandom_range(1, 3);
          else gap = $urandom_range(8, 40);
          if (gap > 0) idle(gap);
        end
        // now and then hold off until the block has answered everything
        if ($urandom_range(0, 99) < 3) drain();
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
